// File: rtl/rabs_pkg.sv
// Shared types, constants and arithmetic helpers for the running-average
// background subtraction block and its port checker.
// No dependencies.
package rabs_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 524288;
  localparam int unsigned CHANNELS_DEF   = 3;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned BKG_W   = 24;
  localparam int unsigned LRATE_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Gray weights, 14-bit fixed point, plus rounding half
  localparam logic [13:0] GRAY_W_BLUE  = 14'd1868;
  localparam logic [13:0] GRAY_W_GREEN = 14'd9617;
  localparam logic [13:0] GRAY_W_RED   = 14'd4899;
  localparam logic [21:0] GRAY_ROUND   = 22'd8192;

  localparam logic [7:0]         THRESH_RST    = 8'd25;
  localparam logic [LRATE_W-1:0] LRATE_RST     = 9'd13;
  localparam logic [LRATE_W-1:0] LRATE_FULL    = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_THRESHOLD   = 2'd0,
    CFG_LEARN_RATE       = 2'd1,
    CFG_SELECTIVE_UPDATE = 2'd2,
    CFG_COLOR_MODE       = 2'd3
  } cfg_idx_t;

  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] r);
    logic [21:0] acc;
    acc = 22'(b) * 22'(GRAY_W_BLUE) + 22'(g) * 22'(GRAY_W_GREEN)
        + 22'(r) * 22'(GRAY_W_RED) + GRAY_ROUND;
    return acc[21:14];
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff8(input logic [PIX_W-1:0] x,
                                                 input logic [PIX_W-1:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

  // (a*pix + (256-a)*old + 128) >> 8, a already clamped to 256
  function automatic logic [PIX_W-1:0] blend8(input logic [PIX_W-1:0]   pix,
                                              input logic [PIX_W-1:0]   old,
                                              input logic [LRATE_W-1:0] a,
                                              input logic [LRATE_W-1:0] a_inv);
    logic [16:0] acc;
    acc = 17'(a) * 17'(pix) + 17'(a_inv) * 17'(old) + 17'd128;
    return acc[15:8];
  endfunction

endpackage

// File: rtl/running_average_background_subtraction.sv
// Running-average background subtraction, one pixel per transaction.
// Depends on rabs_pkg. Background frame held in one synchronous RAM.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   in      | in_valid / in_ready   | blue, green, red, load_background,
//           |                       | end_of_frame
//   out     | out_valid / out_ready | mask_ch0..2, diff_ch0..2, frame_done
//   cfg     | cfg_write             | cfg_index, cfg_data (no handshake back)
//
// One pixel per cycle sustained while out_ready is high; the accept edge reads
// the background RAM, stage 1 compares, blends and writes back, and the output
// register holds results; a same-address write on the read edge is forwarded.
// rst clears the pixel counter, pipeline valids and config; RAM is not cleared.
// out_ready low stalls the compare stage, and in turn in_ready.
module running_average_background_subtraction
  import rabs_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int unsigned CHANNELS   = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      blue,
  input  logic [PIX_W-1:0]      green,
  input  logic [PIX_W-1:0]      red,
  input  logic                  load_background,
  input  logic                  end_of_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  mask_ch0,
  output logic                  mask_ch1,
  output logic                  mask_ch2,
  output logic [PIX_W-1:0]      diff_ch0,
  output logic [PIX_W-1:0]      diff_ch1,
  output logic [PIX_W-1:0]      diff_ch2,
  output logic                  frame_done,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(MAX_PIXELS);
  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_PIXELS - 1);

  // configuration
  logic [PIX_W-1:0]   diff_threshold;
  logic [LRATE_W-1:0] learn_rate;
  logic               selective_update;
  logic               color_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold   <= THRESH_RST;
      learn_rate       <= LRATE_RST;
      selective_update <= 1'b0;
      color_mode       <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIFF_THRESHOLD:   diff_threshold   <= cfg_data[PIX_W-1:0];
        CFG_LEARN_RATE:       learn_rate       <= cfg_data[LRATE_W-1:0];
        CFG_SELECTIVE_UPDATE: selective_update <= cfg_data[0];
        CFG_COLOR_MODE:       color_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid;
  logic s1_adv;
  logic in_fire;
  logic wr_en;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = s1_valid && s1_adv;

  // pixel counter
  logic [AW-1:0] pixel_address;
  logic [AW-1:0] pixel_address_next;

  assign pixel_address_next = (end_of_frame || pixel_address == ADDR_LAST) ? '0
                            : pixel_address + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_address <= '0;
    end else if (in_fire) begin
      pixel_address <= pixel_address_next;
    end
  end

  // stage 1 payload
  logic [PIX_W-1:0] s1_pix [3];
  logic [PIX_W-1:0] s1_gray;
  logic             s1_load;
  logic             s1_eof;
  logic [AW-1:0]    s1_addr;
  logic             byp_hit;
  logic [BKG_W-1:0] byp_data;
  logic [BKG_W-1:0] rd_data;
  logic [BKG_W-1:0] new_bkg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix[0] <= blue;
      s1_pix[1] <= green;
      s1_pix[2] <= red;
      s1_gray   <= gray_of(blue, green, red);
      s1_load   <= load_background;
      s1_eof    <= end_of_frame;
      s1_addr   <= pixel_address;
      // the RAM returns the old word if it is written on the read edge
      byp_hit   <= wr_en && (s1_addr == pixel_address);
      byp_data  <= new_bkg;
    end
  end

  // background RAM
  logic [BKG_W-1:0] bkg_mem [MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bkg_mem[s1_addr] <= new_bkg;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= bkg_mem[pixel_address];
    end
  end

  // compare and blend
  logic [BKG_W-1:0]   old_bkg;
  logic [LRATE_W-1:0] a_eff;
  logic [LRATE_W-1:0] a_inv;
  logic [PIX_W-1:0]   diff [3];
  logic [2:0]         mask;

  assign old_bkg = byp_hit ? byp_data : rd_data;
  assign a_eff   = (learn_rate > LRATE_FULL) ? LRATE_FULL : learn_rate;
  assign a_inv   = LRATE_FULL - a_eff;

  always_comb begin
    new_bkg = old_bkg;
    mask    = '0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = '0;
    end
    if (s1_load) begin
      new_bkg = color_mode ? {s1_pix[2], s1_pix[1], s1_pix[0]}
                           : {16'h0000, s1_gray};
    end else if (!color_mode) begin
      diff[0] = abs_diff8(s1_gray, old_bkg[7:0]);
      mask[0] = diff[0] > diff_threshold;
      if (!(selective_update && mask[0])) begin
        new_bkg[7:0] = blend8(s1_gray, old_bkg[7:0], a_eff, a_inv);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (i < CHANNELS) begin
          diff[i] = abs_diff8(s1_pix[i], old_bkg[8*i +: 8]);
          mask[i] = diff[i] > diff_threshold;
          if (!(selective_update && mask[i])) begin
            new_bkg[8*i +: 8] = blend8(s1_pix[i], old_bkg[8*i +: 8], a_eff, a_inv);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_ch0   <= mask[0];
      mask_ch1   <= mask[1];
      mask_ch2   <= mask[2];
      diff_ch0   <= diff[0];
      diff_ch1   <= diff[1];
      diff_ch2   <= diff[2];
      frame_done <= s1_eof;
    end
  end

endmodule

// File: rtl/rabs_checker.sv
// Port-level checker for the background subtraction block, bound to the top.
// Depends on rabs_pkg; mirrors the threshold and color mode registers from cfg writes.
module rabs_checker
  import rabs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  mask_ch0,
  input logic                  mask_ch1,
  input logic                  mask_ch2,
  input logic [PIX_W-1:0]      diff_ch0,
  input logic [PIX_W-1:0]      diff_ch1,
  input logic [PIX_W-1:0]      diff_ch2,
  input logic                  frame_done,
  input logic                  cfg_write,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PIX_W-1:0] thr_seen;
  logic             color_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_seen   <= THRESH_RST;
      color_seen <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_idx_t'(cfg_index) == CFG_DIFF_THRESHOLD) begin
        thr_seen <= cfg_data[PIX_W-1:0];
      end
      if (cfg_idx_t'(cfg_index) == CFG_COLOR_MODE) begin
        color_seen <= cfg_data[0];
      end
    end
  end

  // each mask is exactly the thresholded difference shown beside it
  a_mask_matches_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mask_ch0 == (diff_ch0 > thr_seen)) &&
                  (mask_ch1 == (diff_ch1 > thr_seen)) &&
                  (mask_ch2 == (diff_ch2 > thr_seen)))
    else $error("mask does not match diff against threshold");

  // gray mode drives only channel 0
  a_gray_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !color_seen) |-> (diff_ch1 == '0) && (diff_ch2 == '0) &&
                                   !mask_ch1 && !mask_ch2)
    else $error("gray mode result has nonzero upper channels");

  // a transaction in with the output free shows up through stage 1 and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
    else $error("result missing after accepted pixel");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(diff_ch0) &&
                                  $stable(frame_done) && $stable(mask_ch0))
    else $error("stalled result changed");

endmodule

bind running_average_background_subtraction rabs_checker u_rabs_checker (.*);
